// ===== src/http_chunked_body_decoder_unit_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros for the chunked body decoder
// shared property forms, clocked on clk and held off during rst
// ---------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_UNIT_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_UNIT_MACROS_SVH

// same-cycle implication
`define HCBD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hcbd same-cycle check failed");

// next-cycle implication
`define HCBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hcbd next-cycle check failed");

`endif

// ===== src/hcbd_pkg.sv =====
// ---------------------------------------------------------------------------
// hcbd_pkg
// types, constants and helpers for the chunked body decoder
// ---------------------------------------------------------------------------
package hcbd_pkg;

  localparam int SIZE_LINE_CHARS_DEFAULT = 15;
  localparam int ADDRESS_BITS_DEFAULT    = 17;

  localparam int CAPACITY_W = 18;
  localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = 18'd65536;

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;

  localparam int SIZE_W = 32;

  typedef enum logic [1:0] {
    PH_SIZE    = 2'd0,
    PH_DATA    = 2'd1,
    PH_TRAILER = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t h;
    h.ok    = 1'b0;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok    = 1'b1;
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.ok    = 1'b1;
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.ok    = 1'b1;
      h.value = 4'(c - 8'h37);
    end
    return h;
  endfunction

endpackage

// ===== src/http_chunked_body_decoder_unit.sv =====
// an accepted beat is held in the input register, then decoded into the output register once that is free
// throughput: one beat per cycle while m_axis_tready stays high, set by the state update
// both sides are decoupled by an input register and an output register
// rst is synchronous: capacity returns to 65536 and the transfer state clears
// ---------------------------------------------------------------------------
// http_chunked_body_decoder_unit
// decodes a chunked http body into payload buffer writes, one byte a beat
// ---------------------------------------------------------------------------
`include "http_chunked_body_decoder_unit_macros.svh"

module http_chunked_body_decoder_unit #(
  parameter int SIZE_LINE_CHARS = hcbd_pkg::SIZE_LINE_CHARS_DEFAULT,
  parameter int ADDRESS_BITS    = hcbd_pkg::ADDRESS_BITS_DEFAULT,
  localparam int OFFSET_W = ADDRESS_BITS + 1,
  localparam int OUT_RAW  = 2 * ADDRESS_BITS + 12,
  localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            capacity_wr_en,
  input  logic [hcbd_pkg::CAPACITY_W-1:0] capacity_wr_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // data_byte
  input  logic [0:0]                      s_axis_tuser,  // command
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // write_valid, write_address, write_data, received_length, overflow_flag,
  // finished, zero fill
  output logic [OUT_W-1:0]                m_axis_tdata
);

  localparam int CNT_W = $clog2(SIZE_LINE_CHARS + 1);
  localparam int CMP_W = (OFFSET_W > hcbd_pkg::CAPACITY_W) ? OFFSET_W : hcbd_pkg::CAPACITY_W;
  localparam logic [CMP_W-1:0] ADDR_LIMIT = CMP_W'(1) << ADDRESS_BITS;

  logic [hcbd_pkg::CAPACITY_W-1:0] capacity;

  logic       in_valid;
  logic       in_cmd;
  logic [7:0] in_byte;

  logic out_valid;
  logic load;

  hcbd_pkg::phase_t             phase, phase_next;
  logic [hcbd_pkg::SIZE_W-1:0]  size_value, size_value_next;
  logic [CNT_W-1:0]             digit_count, digit_count_next;
  logic                         digits_stopped, digits_stopped_next;
  logic [hcbd_pkg::SIZE_W-1:0]  chunk_left, chunk_left_next;
  logic [OFFSET_W-1:0]          write_offset, write_offset_next;
  logic                         overflowed, overflowed_next;

  logic                    wr_valid;
  logic [ADDRESS_BITS-1:0] wr_address;
  logic [7:0]              wr_data;

  hcbd_pkg::hex_digit_t hex;
  logic [CMP_W-1:0]     cap_ext;
  logic [CMP_W-1:0]     cap_lim;
  logic [CMP_W-1:0]     off_ext;

  logic                    out_wr_valid;
  logic [ADDRESS_BITS-1:0] out_wr_address;
  logic [7:0]              out_wr_data;
  logic [OFFSET_W-1:0]     out_length;
  logic                    out_overflow;
  logic                    out_finished;

  assign load          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || load;
  assign m_axis_tvalid = out_valid;

  assign m_axis_tdata = {{(OUT_W - OUT_RAW){1'b0}}, out_finished, out_overflow, out_length,
                         out_wr_data, out_wr_address, out_wr_valid};

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= hcbd_pkg::CAPACITY_RESET;
    end else if (capacity_wr_en) begin
      capacity <= capacity_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd  <= s_axis_tuser[0];
      in_byte <= s_axis_tdata;
    end
  end

  assign hex     = hcbd_pkg::hex_decode(in_byte);
  assign cap_ext = CMP_W'(capacity);
  assign cap_lim = (cap_ext > ADDR_LIMIT) ? ADDR_LIMIT : cap_ext;
  assign off_ext = CMP_W'(write_offset);

  always_comb begin
    phase_next          = phase;
    size_value_next     = size_value;
    digit_count_next    = digit_count;
    digits_stopped_next = digits_stopped;
    chunk_left_next     = chunk_left;
    write_offset_next   = write_offset;
    overflowed_next     = overflowed;
    wr_valid            = 1'b0;
    wr_address          = '0;
    wr_data             = '0;
    if (in_cmd) begin
      phase_next          = hcbd_pkg::PH_SIZE;
      size_value_next     = '0;
      digit_count_next    = '0;
      digits_stopped_next = 1'b0;
      chunk_left_next     = '0;
      write_offset_next   = '0;
      overflowed_next     = 1'b0;
    end else begin
      case (phase)
        hcbd_pkg::PH_SIZE: begin
          if (in_byte == hcbd_pkg::CHAR_LF) begin
            chunk_left_next     = size_value;
            size_value_next     = '0;
            digit_count_next    = '0;
            digits_stopped_next = 1'b0;
            phase_next = (size_value == '0) ? hcbd_pkg::PH_DONE : hcbd_pkg::PH_DATA;
          end else if (in_byte != hcbd_pkg::CHAR_CR &&
                       digit_count < CNT_W'(SIZE_LINE_CHARS)) begin
            digit_count_next = digit_count + CNT_W'(1);
            if (!hex.ok) begin
              digits_stopped_next = 1'b1;
            end else if (!digits_stopped) begin
              // saturate once a digit would shift out of the top
              size_value_next = (|size_value[31:28]) ? '1 : {size_value[27:0], hex.value};
            end
          end
        end
        hcbd_pkg::PH_DATA: begin
          if (!overflowed) begin
            if (off_ext < cap_lim) begin
              wr_valid          = 1'b1;
              wr_address        = write_offset[ADDRESS_BITS-1:0];
              wr_data           = in_byte;
              write_offset_next = write_offset + OFFSET_W'(1);
              if (off_ext + CMP_W'(1) >= cap_lim) begin
                overflowed_next = 1'b1;
              end
            end else begin
              overflowed_next = 1'b1;
            end
          end
          chunk_left_next = chunk_left - hcbd_pkg::SIZE_W'(1);
          if (chunk_left == hcbd_pkg::SIZE_W'(1)) begin
            phase_next = hcbd_pkg::PH_TRAILER;
          end
        end
        hcbd_pkg::PH_TRAILER: begin
          if (in_byte == hcbd_pkg::CHAR_LF) begin
            phase_next = hcbd_pkg::PH_SIZE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // transfer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= hcbd_pkg::PH_SIZE;
      size_value     <= '0;
      digit_count    <= '0;
      digits_stopped <= 1'b0;
      chunk_left     <= '0;
      write_offset   <= '0;
      overflowed     <= 1'b0;
    end else if (load) begin
      phase          <= phase_next;
      size_value     <= size_value_next;
      digit_count    <= digit_count_next;
      digits_stopped <= digits_stopped_next;
      chunk_left     <= chunk_left_next;
      write_offset   <= write_offset_next;
      overflowed     <= overflowed_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_wr_valid   <= wr_valid;
      out_wr_address <= wr_address;
      out_wr_data    <= wr_data;
      out_length     <= write_offset_next;
      out_overflow   <= overflowed_next;
      out_finished   <= (phase_next == hcbd_pkg::PH_DONE);
    end
  end

  // a shown write always sits just below the reported length
  `HCBD_ASSERT_SAME(a_write_matches_length, out_valid && out_wr_valid, (OFFSET_W'(out_wr_address) + OFFSET_W'(1)) == out_length)

  // no payload beat once the terminating chunk is seen
  `HCBD_ASSERT_SAME(a_no_write_when_finished, out_valid && out_finished, !out_wr_valid)

  // overflow stays set until a start command
  `HCBD_ASSERT_NEXT(a_overflow_sticky, overflowed && !(load && in_cmd), overflowed)

  // a held result beat keeps its payload
  `HCBD_ASSERT_NEXT(a_result_held, out_valid && !m_axis_tready, out_valid && $stable(m_axis_tdata))

endmodule

// ===== test/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// checks the chunked body decoder one beat at a time: every body byte sent is
// run through a local model of the decoder, and each output beat is compared
// field by field with the oldest predicted beat. directed framing, size line
// and capacity cases come first, then randomised chunked transfers with noise,
// under several buffer capacities and random idling on both streams
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int ADDR_BITS = hcbd_pkg::ADDRESS_BITS_DEFAULT;
  localparam int LINE_CHARS = hcbd_pkg::SIZE_LINE_CHARS_DEFAULT;
  localparam int CAPACITY_W = hcbd_pkg::CAPACITY_W;
  localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = hcbd_pkg::CAPACITY_RESET;
  localparam logic [7:0] CHAR_CR = hcbd_pkg::CHAR_CR;
  localparam logic [7:0] CHAR_LF = hcbd_pkg::CHAR_LF;
  localparam int OUT_W = ((2 * ADDR_BITS + 12 + 7) / 8) * 8;
  localparam logic [CAPACITY_W-1:0] ADDR_SPAN = CAPACITY_W'(1 << ADDR_BITS);
  localparam logic [CAPACITY_W-1:0] CAPACITY_ALL_ONES = '1;

  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef struct packed {
    logic                 wv;
    logic [ADDR_BITS-1:0] waddr;
    logic [7:0]           wdata;
    logic [ADDR_BITS:0]   rlen;
    logic                 ovf;
    logic                 fin;
  } dec_beat_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  capacity_wr_en = 1'b0;
  logic [CAPACITY_W-1:0] capacity_wr_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;
  logic [0:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;

  // decoder model state
  logic [CAPACITY_W-1:0] cap_reg = CAPACITY_RESET;
  hcbd_pkg::phase_t      ph = hcbd_pkg::PH_SIZE;
  logic [31:0]           size_acc = '0;
  logic [3:0]            size_chars = '0;
  logic                  size_halted = 1'b0;
  logic [31:0]           chunk_rem = '0;
  logic [ADDR_BITS:0]    wr_offset = '0;
  logic                  ovf_seen = 1'b0;

  dec_beat_t   predicted_beats[$];
  dec_beat_t   seen_beat;
  dec_beat_t   due_beat;
  int unsigned error_count = 0;
  int unsigned sent_bytes = 0;
  int unsigned stall_left = 0;
  bit          fast_path = 1'b0;

  http_chunked_body_decoder_unit DUT (
    .clk              (clk),
    .rst              (rst),
    .capacity_wr_en   (capacity_wr_en),
    .capacity_wr_data (capacity_wr_data),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata)
  );

  always #6 clk = ~clk;

  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    return 5'd0;
  endfunction

  function automatic void predict_decoder_beat(input logic cmd, input logic [7:0] b);
    dec_beat_t             r;
    logic [CAPACITY_W-1:0] eff_cap;
    logic [4:0]            nib;
    logic [35:0]           grown;
    r = '0;
    if (cmd == CMD_START) begin
      ph = hcbd_pkg::PH_SIZE;
      size_acc = '0;
      size_chars = '0;
      size_halted = 1'b0;
      chunk_rem = '0;
      wr_offset = '0;
      ovf_seen = 1'b0;
    end else begin
      case (ph)
        hcbd_pkg::PH_SIZE: begin
          if (b == CHAR_LF) begin
            chunk_rem = size_acc;
            size_acc = '0;
            size_chars = '0;
            size_halted = 1'b0;
            ph = (chunk_rem == 0) ? hcbd_pkg::PH_DONE : hcbd_pkg::PH_DATA;
          end else if (b != CHAR_CR && size_chars < LINE_CHARS) begin
            size_chars++;
            nib = hex_nibble(b);
            if (!nib[4]) begin
              size_halted = 1'b1;
            end else if (!size_halted) begin
              grown = {size_acc, nib[3:0]};
              size_acc = (grown[35:32] != 0) ? 32'hFFFF_FFFF : grown[31:0];
            end
          end
        end
        hcbd_pkg::PH_DATA: begin
          eff_cap = (cap_reg > ADDR_SPAN) ? ADDR_SPAN : cap_reg;
          if (!ovf_seen) begin
            if (CAPACITY_W'(wr_offset) < eff_cap) begin
              r.wv = 1'b1;
              r.waddr = wr_offset[ADDR_BITS-1:0];
              r.wdata = b;
              wr_offset++;
              if (CAPACITY_W'(wr_offset) >= eff_cap) ovf_seen = 1'b1;
            end else begin
              ovf_seen = 1'b1;
            end
          end
          chunk_rem--;
          if (chunk_rem == 0) ph = hcbd_pkg::PH_TRAILER;
        end
        hcbd_pkg::PH_TRAILER: begin
          if (b == CHAR_LF) ph = hcbd_pkg::PH_SIZE;
        end
        default: ;
      endcase
    end
    r.rlen = wr_offset;
    r.ovf = ovf_seen;
    r.fin = (ph == hcbd_pkg::PH_DONE);
    predicted_beats.push_back(r);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] seen);
    if (seen !== want) begin
      $error("%s expected 0x%0h got 0x%0h", name, want, seen);
      error_count++;
    end
  endfunction

  // output side: random stall per beat, compare against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_beat.wv    = m_axis_tdata[0];
      seen_beat.waddr = m_axis_tdata[ADDR_BITS:1];
      seen_beat.wdata = m_axis_tdata[ADDR_BITS+8:ADDR_BITS+1];
      seen_beat.rlen  = m_axis_tdata[2*ADDR_BITS+9:ADDR_BITS+9];
      seen_beat.ovf   = m_axis_tdata[2*ADDR_BITS+10];
      seen_beat.fin   = m_axis_tdata[2*ADDR_BITS+11];
      if (predicted_beats.size() == 0) begin
        $error("output beat 0x%0h with no beat predicted", m_axis_tdata);
        error_count++;
      end else begin
        due_beat = predicted_beats.pop_front();
        check_field("write_valid", 32'(due_beat.wv), 32'(seen_beat.wv));
        check_field("write_address", 32'(due_beat.waddr), 32'(seen_beat.waddr));
        check_field("write_data", 32'(due_beat.wdata), 32'(seen_beat.wdata));
        check_field("received_length", 32'(due_beat.rlen), 32'(seen_beat.rlen));
        check_field("overflow_flag", 32'(due_beat.ovf), 32'(seen_beat.ovf));
        check_field("finished", 32'(due_beat.fin), 32'(seen_beat.fin));
      end
      stall_left = fast_path ? 0 : $urandom_range(0, 17);
    end
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_byte(input logic cmd, input logic [7:0] b);
    int unsigned gap;
    gap = fast_path ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_decoder_beat(cmd, b);
    sent_bytes++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (predicted_beats.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAPACITY_W-1:0] value);
    drain_results();
    repeat (4) @(posedge clk);
    capacity_wr_en <= 1'b1;
    capacity_wr_data <= value;
    @(posedge clk);
    capacity_wr_en <= 1'b0;
    cap_reg = value;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 10) return "0" + 8'(v);
    return ($urandom_range(0, 1) ? "a" : "A") + 8'(v) - 8'd10;
  endfunction

  task automatic send_size_line(input int unsigned value);
    int unsigned digits;
    int          i;
    repeat ($urandom_range(0, 2)) send_byte(CMD_BYTE, "0");
    digits = 1;
    while (digits < 8 && (value >> (4 * digits)) != 0) digits++;
    for (i = digits - 1; i >= 0; i--) send_byte(CMD_BYTE, hex_char(4'(value >> (4 * i))));
    // chunk extension: gathering stops at the semicolon
    if ($urandom_range(0, 3) == 0) begin
      send_byte(CMD_BYTE, ";");
      send_byte(CMD_BYTE, hex_char(4'($urandom_range(0, 15))));
    end
    if ($urandom_range(0, 3) != 0) send_byte(CMD_BYTE, CHAR_CR);
    send_byte(CMD_BYTE, CHAR_LF);
  endtask

  // leading zeros around the character limit, last digit kept or dropped
  task automatic send_long_size_line();
    repeat ($urandom_range(12, 17)) send_byte(CMD_BYTE, "0");
    send_byte(CMD_BYTE, hex_char(4'($urandom_range(1, 15))));
    send_byte(CMD_BYTE, CHAR_CR);
    send_byte(CMD_BYTE, CHAR_LF);
  endtask

  task automatic send_trailer();
    logic [7:0] junk;
    repeat ($urandom_range(0, 2)) begin
      junk = 8'($urandom_range(0, 255));
      if (junk == CHAR_LF) junk = "x";
      send_byte(CMD_BYTE, junk);
    end
    if ($urandom_range(0, 3) != 0) send_byte(CMD_BYTE, CHAR_CR);
    send_byte(CMD_BYTE, CHAR_LF);
  endtask

  task automatic send_noise(input int unsigned count);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) send_byte(CMD_START, 8'($urandom_range(0, 255)));
      else if (pick < 4) send_byte(CMD_BYTE, CHAR_CR);
      else if (pick < 7) send_byte(CMD_BYTE, CHAR_LF);
      else if (pick < 11) send_byte(CMD_BYTE, hex_char(4'($urandom_range(0, 15))));
      else send_byte(CMD_BYTE, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_transfer(input bit broken);
    int unsigned len;
    send_byte(CMD_START, 8'($urandom_range(0, 255)));
    if (broken && $urandom_range(0, 2) == 0) send_long_size_line();
    repeat ($urandom_range(1, 3)) begin
      len = $urandom_range(1, 24);
      send_size_line(len);
      repeat (len) send_byte(CMD_BYTE, 8'($urandom_range(0, 255)));
      if (broken && $urandom_range(0, 2) == 0) send_noise($urandom_range(1, 4));
      send_trailer();
    end
    if (!(broken && $urandom_range(0, 3) == 0)) begin
      send_size_line(0);
      // bytes after the last chunk are ignored
      repeat ($urandom_range(0, 2)) send_byte(CMD_BYTE, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_chunk_framing();
    send_byte(CMD_START, 8'hFF);
    send_byte(CMD_BYTE, "2");
    send_byte(CMD_BYTE, ";");
    send_byte(CMD_BYTE, CHAR_CR);
    send_byte(CMD_BYTE, CHAR_LF);
    send_byte(CMD_BYTE, 8'h00);
    send_byte(CMD_BYTE, 8'hFF);
    send_byte(CMD_BYTE, "z");
    send_byte(CMD_BYTE, CHAR_LF);
    // empty size line ends the transfer
    send_byte(CMD_BYTE, CHAR_LF);
    send_byte(CMD_BYTE, "A");
  endtask

  task automatic test_size_line_edges();
    // hex prefix is not accepted
    send_byte(CMD_START, 8'h00);
    send_byte(CMD_BYTE, "0");
    send_byte(CMD_BYTE, "x");
    send_byte(CMD_BYTE, "1");
    send_byte(CMD_BYTE, CHAR_LF);
    // saturating size, mixed case
    send_byte(CMD_START, 8'h5A);
    send_byte(CMD_BYTE, "9");
    send_byte(CMD_BYTE, "a");
    send_byte(CMD_BYTE, "B");
    send_byte(CMD_BYTE, "c");
    send_byte(CMD_BYTE, "D");
    send_byte(CMD_BYTE, "e");
    send_byte(CMD_BYTE, "F");
    send_byte(CMD_BYTE, "0");
    send_byte(CMD_BYTE, "1");
    send_byte(CMD_BYTE, CHAR_LF);
  endtask

  task automatic test_capacity_limits();
    // zero capacity: payload dropped but still counted down
    write_capacity('0);
    send_byte(CMD_START, 8'h00);
    send_byte(CMD_BYTE, "2");
    send_byte(CMD_BYTE, CHAR_LF);
    send_byte(CMD_BYTE, 8'hA5);
    send_byte(CMD_BYTE, 8'h5A);
    send_byte(CMD_BYTE, CHAR_LF);
    // capacity above the address span, then lowered below the offset mid-chunk
    write_capacity(CAPACITY_ALL_ONES);
    send_byte(CMD_START, 8'h00);
    send_byte(CMD_BYTE, "3");
    send_byte(CMD_BYTE, CHAR_LF);
    send_byte(CMD_BYTE, 8'h81);
    send_byte(CMD_BYTE, 8'h7E);
    write_capacity(CAPACITY_W'(1));
    send_byte(CMD_BYTE, 8'hC3);
    send_byte(CMD_BYTE, CHAR_LF);
  endtask

  task automatic test_random_bodies();
    logic [CAPACITY_W-1:0] caps[9];
    int unsigned           stop_at;
    int unsigned           pick;
    int                    k;
    caps = '{CAPACITY_RESET, ADDR_SPAN, CAPACITY_ALL_ONES, '0, CAPACITY_W'(1),
             CAPACITY_W'(7), CAPACITY_W'(30), CAPACITY_W'(100), '0};
    caps[8] = CAPACITY_W'($urandom_range(0, 64));
    for (k = 0; k < 9; k++) begin
      write_capacity(caps[k]);
      stop_at = sent_bytes + 100;
      while (sent_bytes < stop_at) begin
        fast_path = ($urandom_range(0, 4) == 0);
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          send_transfer(1'b0);
        end else if (pick < 9) begin
          send_transfer(1'b1);
          send_noise($urandom_range(1, 6));
        end else begin
          drain_results();
        end
      end
      fast_path = 1'b0;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_chunk_framing();
    test_size_line_edges();
    test_capacity_limits();
    test_random_bodies();
    drain_results();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/hcbd_pkg.sv
src/http_chunked_body_decoder_unit.sv
test/tb_top.sv
